[design/quaternion_frame_receiver_core_assert.svh]
// Assertion macros used by the checker of the quaternion frame receiver.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef QUATERNION_FRAME_RECEIVER_CORE_ASSERT_SVH
`define QUATERNION_FRAME_RECEIVER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define QFR_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define QFR_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

[design/qfr_pkg.sv]
// Package for the quaternion frame receiver: sizes, constants and shared types.
// Used by the tracker, the result register and the top level; depends on nothing.
`timescale 1ns / 1ps

package qfr_pkg;

	// Default frame length in bytes, checksum byte included.
	localparam int FRAME_LEN_DEF = 10;

	// Payload bytes kept per frame (bytes 1 to 8) and their index width.
	localparam int PAYLOAD_DEPTH = 8;
	localparam int PAYLOAD_IDX_W = $clog2(PAYLOAD_DEPTH);

	localparam int BYTE_W = 8;
	localparam int SUM_W  = 16;
	localparam int QUAT_W = 16;

	// Word reported for every quaternion component on a checksum mismatch.
	localparam logic signed [QUAT_W-1:0] QUAT_ERR = -16'sd1;

	// Outcome of one byte as seen by the frame tracker.
	typedef struct packed {
		logic                     is_final;
		logic                     sum_ok;
		logic signed [QUAT_W-1:0] quat_w;
		logic signed [QUAT_W-1:0] quat_x;
		logic signed [QUAT_W-1:0] quat_y;
		logic signed [QUAT_W-1:0] quat_z;
	} frame_res_t;

endpackage

[design/qfr_frame_track.sv]
// Frame tracker: byte position, running sum and payload bytes of the frame.
// Produces the checksum verdict and quaternion words; uses qfr_pkg.
`timescale 1ns / 1ps

module qfr_frame_track #(
	parameter int FRAME_LEN = qfr_pkg::FRAME_LEN_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [qfr_pkg::BYTE_W-1:0]      rx_byte,
	input  logic                            frame_start,
	input  logic                            commit,
	output qfr_pkg::frame_res_t             res
);

	localparam int POS_W = $clog2(FRAME_LEN);
	localparam logic [POS_W-1:0] POS_LAST  = POS_W'(FRAME_LEN - 1);
	localparam logic [POS_W-1:0] POS_PL_LO = POS_W'(1);
	localparam logic [POS_W-1:0] POS_PL_HI = POS_W'(qfr_pkg::PAYLOAD_DEPTH);

	logic [POS_W-1:0]              pos_q;
	logic [qfr_pkg::SUM_W-1:0]     sum_q;
	logic [qfr_pkg::BYTE_W-1:0]    payload_q [qfr_pkg::PAYLOAD_DEPTH];

	logic [POS_W-1:0]              pos_eff;
	logic [qfr_pkg::SUM_W-1:0]     sum_eff;
	logic                          is_final;
	logic                          pl_wr;
	logic [qfr_pkg::PAYLOAD_IDX_W-1:0] pl_idx;
	logic [POS_W-1:0]              pos_m1;
	logic [qfr_pkg::BYTE_W:0]      folded;
	logic [qfr_pkg::BYTE_W-1:0]    csum;
	logic                          match;

	// Realign to byte 0 on a start flag
	always_comb begin
		pos_eff = frame_start ? '0 : pos_q;
		sum_eff = frame_start ? '0 : sum_q;
	end

	assign is_final = (pos_eff >= POS_LAST);
	assign pl_wr    = (pos_eff >= POS_PL_LO) && (pos_eff <= POS_PL_HI);
	assign pos_m1   = pos_eff - POS_PL_LO;
	assign pl_idx   = pos_m1[qfr_pkg::PAYLOAD_IDX_W-1:0];

	// Fold the sum once, truncate and invert
	assign folded = {1'b0, sum_eff[7:0]} + {1'b0, sum_eff[15:8]};
	assign csum   = ~folded[qfr_pkg::BYTE_W-1:0];
	assign match  = (csum == rx_byte);

	// Assemble the big-endian words, or the error pattern
	always_comb begin
		res.is_final = is_final;
		res.sum_ok   = match;
		if (match) begin
			res.quat_w = {payload_q[0], payload_q[1]};
			res.quat_x = {payload_q[2], payload_q[3]};
			res.quat_y = {payload_q[4], payload_q[5]};
			res.quat_z = {payload_q[6], payload_q[7]};
		end else begin
			res.quat_w = qfr_pkg::QUAT_ERR;
			res.quat_x = qfr_pkg::QUAT_ERR;
			res.quat_y = qfr_pkg::QUAT_ERR;
			res.quat_z = qfr_pkg::QUAT_ERR;
		end
	end

	// Advance position and sum; restart after the checksum byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			sum_q <= '0;
		end else if (commit) begin
			if (is_final) begin
				pos_q <= '0;
				sum_q <= '0;
			end else begin
				pos_q <= pos_eff + POS_W'(1);
				sum_q <= sum_eff + {{(qfr_pkg::SUM_W-qfr_pkg::BYTE_W){1'b0}}, rx_byte};
			end
		end
	end

	// Hold payload bytes 1 to 8
	always_ff @(posedge clk) begin
		if (commit && !is_final && pl_wr) begin
			payload_q[pl_idx] <= rx_byte;
		end
	end

endmodule

[design/qfr_out_reg.sv]
// Result register for the quaternion frame receiver.
// Holds one finished frame result until the downstream side takes it; uses qfr_pkg.
`timescale 1ns / 1ps

module qfr_out_reg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                load,
	input  qfr_pkg::frame_res_t                 res,
	output logic                                free,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [4*qfr_pkg::QUAT_W-1:0]        m_tdata,
	output logic                                m_tuser
);

	logic                            valid_q;
	logic [4*qfr_pkg::QUAT_W-1:0]    data_q;
	logic                            ok_q;

	// Room for a new result when empty or when the held one leaves now
	assign free = !valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (free && load) begin
			data_q <= {res.quat_z, res.quat_y, res.quat_x, res.quat_w};
			ok_q   <= res.sum_ok;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = data_q;
	assign m_tuser  = ok_q;

endmodule

[design/quaternion_frame_receiver_core.sv]
// Top level of the quaternion frame receiver: input register, frame tracker
// and result register. Depends on qfr_pkg, qfr_frame_track and qfr_out_reg.
//
//  Channel | Dir | tdata (low bit up)                     | tuser
//  s_*     | in  | rx_byte[7:0]                           | frame_start
//  m_*     | out | quat_w, quat_x, quat_y, quat_z (16 b)  | sum_ok
//
// One byte per cycle unless a checksum byte waits on a stalled result: a byte
// waits in the input register, where the tracker adds it to the sum and compares
// the checksum, then a frame result lands in the result register.
// Reset clears position, sum and both valid flags; payload bytes are not reset.
// A stalled result only holds the input side when a further checksum byte is
// waiting; other bytes keep flowing.
`timescale 1ns / 1ps

module quaternion_frame_receiver_core #(
	parameter int FRAME_LEN = qfr_pkg::FRAME_LEN_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	input  logic        s_tuser,   // [0] frame_start
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // [15:0] quat_w, [31:16] quat_x, [47:32] quat_y, [63:48] quat_z
	output logic        m_tuser    // [0] sum_ok
);

	logic                          valid_s1;
	logic [qfr_pkg::BYTE_W-1:0]    byte_s1;
	logic                          start_s1;
	qfr_pkg::frame_res_t           res;
	logic                          out_free;
	logic                          advance;

	// Move the held byte on unless its result has nowhere to go
	assign advance  = valid_s1 && (!res.is_final || out_free);
	assign s_tready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1  <= s_tdata;
			start_s1 <= s_tuser;
		end
	end

	qfr_frame_track #(
		.FRAME_LEN (FRAME_LEN)
	) u_track (
		.clk         (clk),
		.arst_n      (arst_n),
		.rx_byte     (byte_s1),
		.frame_start (start_s1),
		.commit      (advance),
		.res         (res)
	);

	qfr_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (advance && res.is_final),
		.res      (res),
		.free     (out_free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

[design/qfr_checker.sv]
// Port-level checker for the quaternion frame receiver, bound to the top level.
// Uses the macros of quaternion_frame_receiver_core_assert.svh.
`timescale 1ns / 1ps
`include "quaternion_frame_receiver_core_assert.svh"

module qfr_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tready,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [63:0] m_tdata,
	input  logic        m_tuser
);

	// A stalled result stays put
	`QFR_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

	// A failed checksum reports all words as minus one
	`QFR_ASSERT_NOW(a_err_words, m_tvalid && !m_tuser, m_tdata == {64{1'b1}})

	// With the result register empty the input side never stalls
	`QFR_ASSERT_NOW(a_ready_empty, !m_tvalid, s_tready)

	// A draining result register never stalls the input side either
	`QFR_ASSERT_NOW(a_ready_drain, m_tready, s_tready)

endmodule

bind quaternion_frame_receiver_core qfr_checker u_qfr_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

[verif/tb_quaternion_frame_receiver_core.sv]
// Self-checking testbench for quaternion_frame_receiver_core: streams sensor frames
// in and checks each frame result against an in-bench frame tracker.
// Depends on qfr_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module tb_quaternion_frame_receiver_core;

	localparam int FRAME_LEN    = qfr_pkg::FRAME_LEN_DEF;
	localparam int RANDOM_BYTES = 1150;
	localparam int HOLD_CYCLES  = 300;
	localparam int CYCLE_LIMIT  = 200000;

	typedef enum int {FK_GOOD, FK_BAD_SUM, FK_CUT, FK_NOISE} frame_kind_t;

	typedef struct {
		logic signed [qfr_pkg::QUAT_W-1:0] w;
		logic signed [qfr_pkg::QUAT_W-1:0] x;
		logic signed [qfr_pkg::QUAT_W-1:0] y;
		logic signed [qfr_pkg::QUAT_W-1:0] z;
		logic                              ok;
	} quat_frame_t;

	// Frame tracker: follows the byte stream and queues the result each
	// checksum byte should produce.
	class quat_frame_checker;
		logic [5:0]                 pos;
		logic [qfr_pkg::SUM_W-1:0]  sum;
		logic [qfr_pkg::BYTE_W-1:0] payload [qfr_pkg::PAYLOAD_DEPTH];
		quat_frame_t                pending_frames [$];
		int                         mismatches;
		int                         good_frames;
		int                         bad_frames;

		function new();
			pos         = '0;
			sum         = '0;
			mismatches  = 0;
			good_frames = 0;
			bad_frames  = 0;
			foreach (payload[i]) payload[i] = '0;
		endfunction

		task report(string msg);
			$display("MISMATCH: %s", msg);
			mismatches++;
		endtask

		// Checksum byte that the current frame would need to pass.
		function logic [qfr_pkg::BYTE_W-1:0] expected_checksum();
			logic [qfr_pkg::SUM_W-1:0] folded;
			folded = {8'h00, sum[7:0]} + {8'h00, sum[15:8]};
			return ~folded[7:0];
		endfunction

		function void absorb_byte(logic [qfr_pkg::BYTE_W-1:0] b, logic start);
			quat_frame_t f;
			if (start) begin
				pos = '0;
				sum = '0;
			end
			if (int'(pos) + 1 < FRAME_LEN) begin
				sum = sum + {8'h00, b};
				if (pos >= 1 && pos <= qfr_pkg::PAYLOAD_DEPTH)
					payload[pos - 1] = b;
				pos = pos + 1;
			end else begin
				// Final byte: emit the frame, then realign to byte 0
				if (expected_checksum() == b) begin
					f.w  = {payload[0], payload[1]};
					f.x  = {payload[2], payload[3]};
					f.y  = {payload[4], payload[5]};
					f.z  = {payload[6], payload[7]};
					f.ok = 1'b1;
				end else begin
					f.w  = qfr_pkg::QUAT_ERR;
					f.x  = qfr_pkg::QUAT_ERR;
					f.y  = qfr_pkg::QUAT_ERR;
					f.z  = qfr_pkg::QUAT_ERR;
					f.ok = 1'b0;
				end
				pending_frames.push_back(f);
				pos = '0;
				sum = '0;
			end
		endfunction

		task check_result(logic [63:0] data, logic ok);
			quat_frame_t want;
			if (pending_frames.size() == 0) begin
				report($sformatf("unexpected result tdata=%h tuser=%0b", data, ok));
				return;
			end
			want = pending_frames.pop_front();
			if (data[15:0] !== want.w)
				report($sformatf("quat_w %h, expected %h", data[15:0], want.w));
			if (data[31:16] !== want.x)
				report($sformatf("quat_x %h, expected %h", data[31:16], want.x));
			if (data[47:32] !== want.y)
				report($sformatf("quat_y %h, expected %h", data[47:32], want.y));
			if (data[63:48] !== want.z)
				report($sformatf("quat_z %h, expected %h", data[63:48], want.z));
			if (ok !== want.ok)
				report($sformatf("sum_ok %b, expected %b", ok, want.ok));
			if (want.ok)
				good_frames++;
			else
				bad_frames++;
		endtask
	endclass

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata  = '0;
	logic        s_tuser  = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [63:0] m_tdata;
	logic        m_tuser;

	quat_frame_checker sb = new();

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int bytes_sent     = 0;
	int cycles         = 0;
	logic hold_start   = 1'b0;
	logic hold_done    = 1'b0;
	int hold_cnt       = 0;

	quaternion_frame_receiver_core #(
		.FRAME_LEN(FRAME_LEN)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	always #1 clk = ~clk;

	// Abort a run that stops making progress
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Result side: check accepted results, stall at random, hold off once
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata, m_tuser);
		if (hold_start && !hold_done) begin
			m_tready <= 1'b0;
			hold_cnt <= hold_cnt + 1;
			if (hold_cnt == HOLD_CYCLES - 1)
				hold_done <= 1'b1;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	function automatic logic [7:0] rand_byte();
		logic [7:0] corner [4] = '{8'h00, 8'hFF, 8'h80, 8'h7F};
		if ($urandom_range(3) == 0)
			return corner[$urandom_range(3)];
		return 8'($urandom_range(255));
	endfunction

	// Offer one byte, idling first at random, and wait for its acceptance
	task automatic send_byte(input logic [7:0] b, input logic start);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tuser  <= start;
		do @(posedge clk); while (!s_tready);
		sb.absorb_byte(b, start);
		bytes_sent++;
	endtask

	// Send one frame of the given kind with random content
	task automatic send_frame(input frame_kind_t kind, input logic with_start);
		int n;
		logic [7:0] chk;
		if (kind == FK_NOISE) begin
			n = $urandom_range(5, 1);
			repeat (n) send_byte(rand_byte(), 1'($urandom_range(1)));
			return;
		end
		n = (kind == FK_CUT) ? $urandom_range(FRAME_LEN - 1, 1) : FRAME_LEN - 1;
		send_byte(rand_byte(), with_start);
		repeat (n - 1) send_byte(rand_byte(), 1'b0);
		if (kind == FK_CUT)
			return;
		chk = sb.expected_checksum();
		if (kind == FK_BAD_SUM)
			chk = chk ^ (8'h01 << $urandom_range(7));
		send_byte(chk, 1'b0);
	endtask

	initial begin
		logic [7:0] f1 [9] = '{8'hA5, 8'h80, 8'h00, 8'h7F, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00};
		frame_kind_t kind;
		int r;
		int rand_start;
		logic aligned;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: first frame straight after reset with no start flag,
		// payload giving the most negative, most positive, -1 and zero words
		foreach (f1[i]) send_byte(f1[i], 1'b0);
		send_byte(sb.expected_checksum(), 1'b0);

		// Directed: start flag landing on the checksum position drops the
		// frame; the restarted frame then ends on a bad checksum
		send_byte(8'h5A, 1'b1);
		for (int i = 1; i < FRAME_LEN - 1; i++) send_byte(8'(i), 1'b0);
		send_byte(8'h3C, 1'b1);
		repeat (FRAME_LEN - 2) send_byte(8'hFF, 1'b0);
		send_byte(sb.expected_checksum() ^ 8'h80, 1'b0);

		// Random frames across four idling phases; long hold-off in the first
		hold_start <= 1'b1;
		rand_start = bytes_sent;
		aligned = 1'b1;
		while (bytes_sent - rand_start < RANDOM_BYTES) begin
			case ((bytes_sent - rand_start) * 4 / RANDOM_BYTES)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
				default: begin send_idle_pct = 17; recv_stall_pct = 17; end
			endcase
			r = $urandom_range(99);
			if (r < 70)
				kind = FK_GOOD;
			else if (r < 80)
				kind = FK_BAD_SUM;
			else if (r < 90)
				kind = FK_CUT;
			else
				kind = FK_NOISE;
			send_frame(kind, aligned ? 1'($urandom_range(9) != 0) : 1'b1);
			aligned = (kind == FK_GOOD || kind == FK_BAD_SUM);
		end
		s_tvalid <= 1'b0;

		// Drain outstanding results, then watch for strays
		recv_stall_pct = 0;
		while (sb.pending_frames.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		$display("Streamed %0d bytes; checked %0d good frames and %0d checksum failures.",
			bytes_sent, sb.good_frames, sb.bad_frames);
		$display("Ran with no idling, sender gaps, output stalls, both, and one long hold-off.");
		if (sb.mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

[files.f]
+incdir+design
design/qfr_pkg.sv
design/qfr_frame_track.sv
design/qfr_out_reg.sv
design/quaternion_frame_receiver_core.sv
design/qfr_checker.sv
verif/tb_quaternion_frame_receiver_core.sv
